// File: rtl/fbld_pkg.sv
// ----------------------------------------------------------------------------
// fbld_pkg
// Shared types and constants for the body line deframer: result kinds,
// parse modes, result records and the register reset value.
// ----------------------------------------------------------------------------
package fbld_pkg;

	// Default upper bound on the line room
	localparam int unsigned MAX_LINE_ROOM_DEF = 4096;
	// Smallest usable line room
	localparam int unsigned LINE_ROOM_MIN = 4;
	// Bytes kept back from the room when closing a line
	localparam int unsigned ROOM_MARGIN = 3;

	localparam int unsigned ROOM_W = 13;
	localparam logic [ROOM_W-1:0] LINE_ROOM_RESET = 13'd4096;

	// Special body bytes
	localparam logic [7:0] BYTE_CR   = 8'h0d;
	localparam logic [7:0] BYTE_LF   = 8'h0a;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_TWO  = 8'h02;

	typedef enum logic [2:0] {
		KIND_BYTE     = 3'd0,
		KIND_LINE_END = 3'd1,
		KIND_MSG_END  = 3'd2,
		KIND_PKT_END  = 3'd3,
		KIND_ERROR    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_AFTER_CR = 3'd1,
		MODE_ZERO1    = 3'd2,
		MODE_ZERO2    = 3'd3,
		MODE_TWO1     = 3'd4
	} mode_t;

	// One result record
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// Parser state apart from the line count
	typedef struct packed {
		mode_t      mode;
		logic [7:0] held;
	} pstate_t;

	// Everything one item produces: up to three results and the next state
	typedef struct packed {
		res_t [2:0] res;
		logic [1:0] num;
		pstate_t    nxt;
	} step_t;

endpackage

// File: rtl/ftn_body_line_deframer.sv
// ----------------------------------------------------------------------------
// ftn_body_line_deframer
// Splits a message body, one byte per item, into line bytes, line ends,
// message ends, packet ends and errors.
// ----------------------------------------------------------------------------
// An accepted item is registered, parsed in the following cycle, and its
// results (zero to three) are loaded into a result register that hands out
// one result per transfer. A stream of items that yield at most one result
// each flows at one item per clock while res_ready stays high; an item that
// yields several results holds the result register until its last result
// is taken, and an item that yields none does not hold it. The first result
// is offered once its item has passed the input register and been loaded
// into the result register. line_room may be written only while the block
// is idle; it is clamped to 4..MAX_LINE_ROOM.
// ----------------------------------------------------------------------------
module ftn_body_line_deframer #(
	parameter int unsigned MAX_LINE_ROOM = fbld_pkg::MAX_LINE_ROOM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [fbld_pkg::ROOM_W-1:0]   cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [7:0]                    body_byte,
	input  logic                          end_of_input,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [2:0]                    kind,
	output logic [7:0]                    line_byte,
	output logic                          last
);

	localparam int unsigned CNT_W = $clog2(MAX_LINE_ROOM);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          eoi_s1;
	logic [fbld_pkg::ROOM_W-1:0]   room_q;
	fbld_pkg::pstate_t             state_q;
	logic [CNT_W-1:0]              count_q;
	fbld_pkg::step_t               step;
	logic [CNT_W-1:0]              count_nxt;
	logic                          buf_free;
	logic                          advance;

	assign advance    = valid_s1 && buf_free;
	assign item_ready = !valid_s1 || buf_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= fbld_pkg::LINE_ROOM_RESET;
		end else if (cfg_wen) begin
			room_q <= cfg_wdata;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1 <= body_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Parser state: advance when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: fbld_pkg::MODE_NORMAL, held: 8'h00};
			count_q <= '0;
		end else if (advance) begin
			state_q <= step.nxt;
			count_q <= count_nxt;
		end
	end

	fbld_parse #(
		.MAX_LINE_ROOM (MAX_LINE_ROOM),
		.CNT_W         (CNT_W)
	) u_parse (
		.cur          (state_q),
		.count        (count_q),
		.room         (room_q),
		.body_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.step         (step),
		.count_nxt    (count_nxt)
	);

	fbld_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.step      (step),
		.free      (buf_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.line_byte (line_byte),
		.last      (last)
	);

endmodule

// File: rtl/fbld_parse.sv
// ----------------------------------------------------------------------------
// fbld_parse
// Combinational parse step: from the current state and one body byte or
// end-of-input mark, form up to three results and the next state.
// ----------------------------------------------------------------------------
module fbld_parse #(
	parameter int unsigned MAX_LINE_ROOM = fbld_pkg::MAX_LINE_ROOM_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_LINE_ROOM)
) (
	input  fbld_pkg::pstate_t               cur,
	input  logic [CNT_W-1:0]                count,
	input  logic [fbld_pkg::ROOM_W-1:0]     room,
	input  logic [7:0]                      body_byte,
	input  logic                            end_of_input,
	output fbld_pkg::step_t                 step,
	output logic [CNT_W-1:0]                count_nxt
);

	localparam int unsigned CMP_W =
		((CNT_W > fbld_pkg::ROOM_W) ? CNT_W : fbld_pkg::ROOM_W) + 2;

	logic [CMP_W-1:0] room_ext;
	logic [CMP_W-1:0] room_eff;

	// Clamp the room into its legal range
	always_comb begin
		room_ext = CMP_W'(room);
		if (room_ext < CMP_W'(fbld_pkg::LINE_ROOM_MIN)) begin
			room_eff = CMP_W'(fbld_pkg::LINE_ROOM_MIN);
		end else if (room_ext > CMP_W'(MAX_LINE_ROOM)) begin
			room_eff = CMP_W'(MAX_LINE_ROOM);
		end else begin
			room_eff = room_ext;
		end
	end

	// Walk the byte through the parser
	always_comb begin : p_step
		fbld_pkg::res_t [2:0] r;
		logic [1:0]           n;
		fbld_pkg::mode_t      m;
		logic [7:0]           h;
		logic [CMP_W-1:0]     c;
		logic                 do_normal;
		logic                 do_close;

		r         = '{default: '{kind: fbld_pkg::KIND_BYTE, data: 8'h00}};
		n         = 2'd0;
		m         = cur.mode;
		h         = cur.held;
		c         = CMP_W'(count);
		do_normal = 1'b0;
		do_close  = 1'b0;

		if (end_of_input) begin
			if (m == fbld_pkg::MODE_AFTER_CR) begin
				r[n] = '{kind: fbld_pkg::KIND_LINE_END, data: 8'h00};
				n    = n + 2'd1;
			end
			r[n] = '{kind: fbld_pkg::KIND_ERROR, data: 8'h00};
			n    = n + 2'd1;
			m    = fbld_pkg::MODE_NORMAL;
			h    = 8'h00;
			c    = '0;
		end else begin
			case (m)
				fbld_pkg::MODE_AFTER_CR: begin
					if (body_byte == fbld_pkg::BYTE_LF) begin
						r[n]     = '{kind: fbld_pkg::KIND_BYTE, data: body_byte};
						n        = n + 2'd1;
						c        = c + CMP_W'(1);
						do_close = 1'b1;
					end else begin
						r[n]      = '{kind: fbld_pkg::KIND_LINE_END, data: 8'h00};
						n         = n + 2'd1;
						m         = fbld_pkg::MODE_NORMAL;
						h         = 8'h00;
						c         = '0;
						do_normal = 1'b1;
					end
				end
				fbld_pkg::MODE_ZERO1: begin
					h = body_byte;
					m = fbld_pkg::MODE_ZERO2;
				end
				fbld_pkg::MODE_ZERO2: begin
					if (h == fbld_pkg::BYTE_TWO && body_byte == fbld_pkg::BYTE_ZERO) begin
						r[n] = '{kind: fbld_pkg::KIND_MSG_END, data: 8'h00};
						n    = n + 2'd1;
						m    = fbld_pkg::MODE_NORMAL;
						h    = 8'h00;
						c    = '0;
					end else if (h == fbld_pkg::BYTE_ZERO &&
							body_byte == fbld_pkg::BYTE_ZERO) begin
						r[n] = '{kind: fbld_pkg::KIND_PKT_END, data: 8'h00};
						n    = n + 2'd1;
						m    = fbld_pkg::MODE_NORMAL;
						h    = 8'h00;
						c    = '0;
					end else begin
						// Orphan group: keep its nonzero bytes
						m = fbld_pkg::MODE_NORMAL;
						if (h != fbld_pkg::BYTE_ZERO) begin
							r[n] = '{kind: fbld_pkg::KIND_BYTE, data: h};
							n    = n + 2'd1;
							c    = c + CMP_W'(1);
						end
						if (body_byte != fbld_pkg::BYTE_ZERO) begin
							r[n] = '{kind: fbld_pkg::KIND_BYTE, data: body_byte};
							n    = n + 2'd1;
							c    = c + CMP_W'(1);
						end
						h        = 8'h00;
						do_close = 1'b1;
					end
				end
				fbld_pkg::MODE_TWO1: begin
					if (body_byte == fbld_pkg::BYTE_ZERO) begin
						// Mangled message end
						r[n] = '{kind: fbld_pkg::KIND_MSG_END, data: 8'h00};
						n    = n + 2'd1;
						m    = fbld_pkg::MODE_NORMAL;
						h    = 8'h00;
						c    = '0;
					end else begin
						m        = fbld_pkg::MODE_NORMAL;
						r[n]     = '{kind: fbld_pkg::KIND_BYTE, data: fbld_pkg::BYTE_TWO};
						n        = n + 2'd1;
						r[n]     = '{kind: fbld_pkg::KIND_BYTE, data: body_byte};
						n        = n + 2'd1;
						c        = c + CMP_W'(2);
						do_close = 1'b1;
					end
				end
				default: begin
					m         = fbld_pkg::MODE_NORMAL;
					do_normal = 1'b1;
				end
			endcase

			// Plain byte at the start of, or inside, a line
			if (do_normal) begin
				if (body_byte == fbld_pkg::BYTE_ZERO) begin
					m = fbld_pkg::MODE_ZERO1;
				end else if (body_byte == fbld_pkg::BYTE_TWO) begin
					m = fbld_pkg::MODE_TWO1;
				end else begin
					if (body_byte == fbld_pkg::BYTE_CR) begin
						m = fbld_pkg::MODE_AFTER_CR;
					end
					r[n]     = '{kind: fbld_pkg::KIND_BYTE, data: body_byte};
					n        = n + 2'd1;
					c        = c + CMP_W'(1);
					do_close = 1'b1;
				end
			end

			// Close the line once its byte count reaches the room less the margin
			if (do_close && (c + CMP_W'(fbld_pkg::ROOM_MARGIN) >= room_eff)) begin
				r[n] = '{kind: fbld_pkg::KIND_LINE_END, data: 8'h00};
				n    = n + 2'd1;
				c    = '0;
				m    = fbld_pkg::MODE_NORMAL;
			end
		end

		step.res      = r;
		step.num      = n;
		step.nxt.mode = m;
		step.nxt.held = h;
		count_nxt     = CNT_W'(c);
	end

endmodule

// File: rtl/fbld_res_buf.sv
// ----------------------------------------------------------------------------
// fbld_res_buf
// Result register: holds the results of one item and hands them out one
// transfer at a time, flagging the final one.
// ----------------------------------------------------------------------------
module fbld_res_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  fbld_pkg::step_t       step,
	output logic                  free,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [2:0]            kind,
	output logic [7:0]            line_byte,
	output logic                  last
);

	fbld_pkg::res_t [2:0] res_s2;
	logic [1:0]           num_q;
	logic [1:0]           idx_q;
	logic                 final_one;

	assign res_valid = (idx_q != num_q);
	assign final_one = ((idx_q + 2'd1) == num_q);
	assign free      = !res_valid || (res_ready && final_one);
	assign kind      = res_s2[idx_q].kind;
	assign line_byte = res_s2[idx_q].data;
	assign last      = final_one;

	// Load a fresh result set, or advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			num_q <= step.num;
			idx_q <= 2'd0;
		end else if (res_valid && res_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= step.res;
		end
	end

endmodule

// File: rtl/fbld_checker.sv
// ----------------------------------------------------------------------------
// fbld_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fbld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] kind,
	input logic [7:0] line_byte,
	input logic       last
);

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) &&
			$stable(line_byte) && $stable(last))
		else $error("result changed while stalled");

	// Only line bytes carry data
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != fbld_pkg::KIND_BYTE |-> line_byte == 8'h00)
		else $error("non-byte result carries data");

	// Errors, message ends and packet ends close their item's results
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == fbld_pkg::KIND_ERROR || kind == fbld_pkg::KIND_MSG_END ||
			kind == fbld_pkg::KIND_PKT_END) |-> last)
		else $error("terminal result not last");

	// A stored zero byte never appears as a line byte
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == fbld_pkg::KIND_BYTE |-> line_byte != 8'h00)
		else $error("zero byte stored in a line");

endmodule

bind ftn_body_line_deframer fbld_checker u_fbld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.kind      (kind),
	.line_byte (line_byte),
	.last      (last)
);

// File: tb/fbld_tb_pkg.sv
// ----------------------------------------------------------------------------
// fbld_tb_pkg
// Line splitting predictor for the body line deframer testbench. It tracks
// the parse mode, the held byte, the line count and the line room, works
// out the results of each transferred item and checks returned results
// against them in order.
// ----------------------------------------------------------------------------
package fbld_tb_pkg;
	import fbld_pkg::*;

	// One predicted result
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		bit         fin;
	} outcome_t;

	class line_splitter_twin;
		logic [ROOM_W-1:0] room;
		mode_t             mode;
		logic [7:0]        held;
		int unsigned       count;
		outcome_t          due[$];
		outcome_t          burst[$];
		int unsigned       slips;
		int unsigned       matched;

		function new();
			room    = LINE_ROOM_RESET;
			mode    = MODE_NORMAL;
			held    = '0;
			count   = 0;
			slips   = 0;
			matched = 0;
		endfunction

		function void set_room(logic [ROOM_W-1:0] v);
			room = v;
		endfunction

		// Clamp the programmed room to the usable range
		function int unsigned room_eff();
			int unsigned r;
			r = room;
			if (r < LINE_ROOM_MIN)
				r = LINE_ROOM_MIN;
			if (r > MAX_LINE_ROOM_DEF)
				r = MAX_LINE_ROOM_DEF;
			return r;
		endfunction

		function void emit(kind_t k, logic [7:0] d);
			outcome_t o;
			o.kind = k;
			o.data = d;
			o.fin  = 1'b0;
			burst.push_back(o);
		endfunction

		function void store(logic [7:0] d);
			emit(KIND_BYTE, d);
			count++;
		endfunction

		// Close the line once the stored bytes reach room less the margin
		function void close_check();
			if (count + ROOM_MARGIN >= room_eff()) begin
				emit(KIND_LINE_END, '0);
				count = 0;
				mode  = MODE_NORMAL;
			end
		endfunction

		function void restart();
			count = 0;
			mode  = MODE_NORMAL;
			held  = '0;
		endfunction

		function void plain_byte(logic [7:0] b);
			if (b == BYTE_ZERO) begin
				mode = MODE_ZERO1;
			end else if (b == BYTE_TWO) begin
				mode = MODE_TWO1;
			end else begin
				store(b);
				if (b == BYTE_CR)
					mode = MODE_AFTER_CR;
				close_check();
			end
		endfunction

		// Predict the results of one transferred item
		function void take_item(logic [7:0] b, bit eoi);
			outcome_t o;
			burst.delete();
			if (eoi) begin
				if (mode == MODE_AFTER_CR)
					emit(KIND_LINE_END, '0);
				emit(KIND_ERROR, '0);
				restart();
			end else begin
				case (mode)
					MODE_AFTER_CR: begin
						if (b == BYTE_LF) begin
							store(b);
							close_check();
						end else begin
							emit(KIND_LINE_END, '0);
							restart();
							plain_byte(b);
						end
					end
					MODE_ZERO1: begin
						held = b;
						mode = MODE_ZERO2;
					end
					MODE_ZERO2: begin
						if (held == BYTE_TWO && b == BYTE_ZERO) begin
							emit(KIND_MSG_END, '0);
							restart();
						end else if (held == BYTE_ZERO && b == BYTE_ZERO) begin
							emit(KIND_PKT_END, '0);
							restart();
						end else begin
							// orphan group: keep its nonzero bytes
							mode = MODE_NORMAL;
							if (held != BYTE_ZERO)
								store(held);
							if (b != BYTE_ZERO)
								store(b);
							held = '0;
							close_check();
						end
					end
					MODE_TWO1: begin
						if (b == BYTE_ZERO) begin
							emit(KIND_MSG_END, '0);
							restart();
						end else begin
							mode = MODE_NORMAL;
							store(BYTE_TWO);
							store(b);
							close_check();
						end
					end
					default: begin
						mode = MODE_NORMAL;
						plain_byte(b);
					end
				endcase
			end
			// mark the final result of the item
			if (burst.size() > 0) begin
				o = burst.pop_back();
				o.fin = 1'b1;
				burst.push_back(o);
			end
			foreach (burst[i])
				due.push_back(burst[i]);
		endfunction

		task slip(string what);
			$display("%0t ns mismatch: %s", $time, what);
			slips++;
		endtask

		// Compare one returned result with the oldest prediction
		task match_result(logic [2:0] k, logic [7:0] d, logic l);
			outcome_t o;
			if (due.size() == 0) begin
				slip($sformatf("unpredicted result kind %0d data %02h last %0b", k, d, l));
				return;
			end
			o = due.pop_front();
			if (k !== o.kind)
				slip($sformatf("kind %0d, predicted %0d", k, o.kind));
			if (d !== o.data)
				slip($sformatf("line byte %02h, predicted %02h", d, o.data));
			if (l !== o.fin)
				slip($sformatf("last %0b, predicted %0b", l, o.fin));
			matched++;
		endtask
	endclass

endpackage

// File: tb/ftn_body_line_deframer_tb.sv
// ----------------------------------------------------------------------------
// ftn_body_line_deframer_tb
// Drives body bytes and end-of-input marks into the line deframer under
// several line room settings, with random idling on both channels and one
// long receiver hold-off, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module ftn_body_line_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbld_pkg::*;
	import fbld_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned HOLD_CYCLES   = 120;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS   = 50;
	localparam int unsigned NUM_PHASES    = 8;
	localparam int unsigned HOLD_PHASE    = 3;
	localparam int unsigned NUM_OPENING   = 26;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [ROOM_W-1:0] cfg_wdata;
	logic              item_valid;
	logic              item_ready;
	logic [7:0]        body_byte;
	logic              end_of_input;
	logic              res_valid;
	logic              res_ready;
	logic [2:0]        kind;
	logic [7:0]        line_byte;
	logic              last;

	line_splitter_twin twin;
	bit                calm;
	bit                hold_ask;
	int unsigned       items_sent;
	int unsigned       rooms_set;

	ftn_body_line_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.body_byte    (body_byte),
		.end_of_input (end_of_input),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.line_byte    (line_byte),
		.last         (last)
	);

	// Clock, 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End the run if it overstays the cycle limit
	initial begin : watchdog
		int unsigned ticks;
		ticks = 0;
		while (ticks < CYCLE_LIMIT) begin
			@(posedge clk);
			ticks++;
		end
		$display("run stopped after %0d cycles with %0d results outstanding",
			ticks, twin.due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: check each transfer, stall in bursts, honour the long hold
	initial begin : result_side
		int unsigned pause;
		pause     = 0;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				twin.match_result(kind, line_byte, last);
			if (hold_ask) begin
				hold_ask = 1'b0;
				pause    = HOLD_CYCLES;
			end else if (pause == 0 && !calm && $urandom_range(0, 9) == 0) begin
				pause = $urandom_range(1, 7);
			end
			if (pause > 0) begin
				res_ready <= 1'b0;
				pause--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Offer one item, after an occasional idle burst, and hold it until transfer
	task automatic send_item(input logic [7:0] b, input bit eoi);
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		body_byte    <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (!item_ready);
		twin.take_item(b, eoi);
		items_sent++;
	endtask

	// Wait for every predicted result, then for the pipeline to empty
	task automatic settle();
		item_valid <= 1'b0;
		while (twin.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_room(input logic [ROOM_W-1:0] v);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		twin.set_room(v);
		rooms_set++;
	endtask

	// Bias towards the bytes that steer the parser
	function automatic logic [7:0] steer_byte();
		case ($urandom_range(0, 5))
			0: return BYTE_ZERO;
			1: return BYTE_TWO;
			2: return BYTE_CR;
			3: return BYTE_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One random sequence: mostly well-formed text and groups, some noise
	task automatic send_chunk();
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			len = $urandom_range(1, 12);
			repeat (len) send_item(8'($urandom_range(3, 255)), 1'b0);
			if ($urandom_range(0, 2) != 0) begin
				send_item(BYTE_CR, 1'b0);
				repeat ($urandom_range(0, 3)) send_item(BYTE_LF, 1'b0);
			end
		end else if (pick < 60) begin
			send_item(BYTE_ZERO, 1'b0);
			send_item(BYTE_TWO, 1'b0);
			send_item(BYTE_ZERO, 1'b0);
		end else if (pick < 65) begin
			repeat (3) send_item(BYTE_ZERO, 1'b0);
		end else if (pick < 75) begin
			send_item(BYTE_ZERO, 1'b0);
			send_item(steer_byte(), 1'b0);
			send_item(steer_byte(), 1'b0);
		end else if (pick < 83) begin
			send_item(BYTE_TWO, 1'b0);
			send_item(steer_byte(), 1'b0);
		end else if (pick < 91) begin
			send_item(BYTE_CR, 1'b0);
			repeat ($urandom_range(1, 3)) send_item(BYTE_LF, 1'b0);
		end else if (pick < 96) begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_item(steer_byte(), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		logic [8:0]        opening [NUM_OPENING];
		logic [ROOM_W-1:0] room_plan [NUM_PHASES];
		int unsigned       target;

		twin         = new();
		calm         = 1'b0;
		hold_ask     = 1'b0;
		items_sent   = 0;
		rooms_set    = 0;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = '0;
		item_valid   = 1'b0;
		body_byte    = '0;
		end_of_input = 1'b0;

		// Bit 8 marks end of input
		opening = '{
			{1'b0, 8'h41}, {1'b0, 8'hff},
			// CR with its LF run, then a byte that opens a new line
			{1'b0, BYTE_CR}, {1'b0, BYTE_LF}, {1'b0, BYTE_LF}, {1'b0, 8'h7e},
			// end of input after CR, then on an empty line
			{1'b0, BYTE_CR}, {1'b1, 8'hff}, {1'b1, 8'h00},
			// message end, packet end
			{1'b0, BYTE_ZERO}, {1'b0, BYTE_TWO}, {1'b0, BYTE_ZERO},
			{1'b0, BYTE_ZERO}, {1'b0, BYTE_ZERO}, {1'b0, BYTE_ZERO},
			// orphan holding a CR: the LF after it is a plain byte
			{1'b0, BYTE_ZERO}, {1'b0, BYTE_CR}, {1'b0, 8'h05}, {1'b0, BYTE_LF},
			// orphan with a zero tail, mangled message end
			{1'b0, BYTE_ZERO}, {1'b0, 8'h09}, {1'b0, BYTE_ZERO},
			{1'b0, BYTE_TWO}, {1'b0, BYTE_ZERO},
			// end of input inside a group, then leave a line open
			{1'b0, BYTE_ZERO}, {1'b1, 8'h00}
		};
		room_plan = '{13'd4, 13'd0, 13'd8191, 13'd16, 13'd4096, 13'd7,
			13'($urandom_range(4, 60)), 13'd5};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_item(opening[i][7:0], opening[i][8]);
		send_item(8'h78, 1'b0);
		send_item(8'h79, 1'b0);

		// Each phase lowers or raises the room while a line may be open
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			write_room(room_plan[p]);
			if (p == HOLD_PHASE)
				hold_ask = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_chunk();
		end

		settle();
		$display("covered %0d items over %0d line room settings, %0d results checked",
			items_sent, rooms_set, twin.matched);
		$display("with idle bursts on both sides, a %0d-cycle receiver hold-off %s",
			HOLD_CYCLES, "and back-to-back traffic at the end");
		if (twin.slips == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", twin.slips);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/fbld_pkg.sv
rtl/fbld_parse.sv
rtl/fbld_res_buf.sv
rtl/ftn_body_line_deframer.sv
rtl/fbld_checker.sv
tb/fbld_tb_pkg.sv
tb/ftn_body_line_deframer_tb.sv
